// ----- rtl/ptd_pkg.sv -----
// shared constants and types for the trial-division primality tester
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;

    localparam int VALUE_BITS_DEF = 31;

    // first odd trial divisor and its square
    localparam int FIRST_CAND = 3;
    localparam int FIRST_SQ   = 9;

    // candidate steps, alternating between the short and the long one
    localparam int STEP_SHORT = 2;
    localparam int STEP_LONG  = 4;

    // status returned by the serial remainder unit
    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage
`default_nettype wire

// ----- rtl/ptd_rem.sv -----
// bit-serial restoring remainder unit, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ptd_rem
    import ptd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [VALUE_BITS-1:0]       i_dividend,
    input  wire logic [VALUE_BITS/2+1:0]     i_divisor,
    output t_rem_status                      o_status
);

    localparam int CAND_BITS = VALUE_BITS / 2 + 2;
    localparam int CNT_BITS  = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] r_shift;
    logic [CAND_BITS-1:0]  r_rem;
    logic [CNT_BITS-1:0]   r_count;
    logic                  r_busy;
    logic                  r_done;

    logic [CAND_BITS:0]    trial;
    logic [CAND_BITS:0]    n_diff;
    logic [CAND_BITS-1:0]  n_rem;

    always_comb begin
        trial  = {r_rem, r_shift[VALUE_BITS-1]};
        n_diff = trial - {1'b0, i_divisor};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem = n_diff[CAND_BITS-1:0];
        end else begin
            n_rem = trial[CAND_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            // pulse once the last dividend bit has been shifted in
            r_done <= !i_start && r_busy && (r_count == CNT_BITS'(1));
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= CNT_BITS'(VALUE_BITS);
            end else if (r_busy) begin
                r_count <= r_count - CNT_BITS'(1);
                if (r_count == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[VALUE_BITS-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule
`default_nettype wire

// ----- rtl/primality_trial_division.sv -----
// top level of the trial-division primality tester
`timescale 1ns / 1ps
`default_nettype none
// takes one unsigned word and answers with one word that is 1 when the value is
// prime. values below 2 and even values other than 2 are settled in S_PRE
// without a division. every other value is divided by 3 and then by each 6k+-1
// from 5 upward while the candidate squared does not exceed the value; the
// square is tracked incrementally with shifts and adds, so there is no
// multiplier. each candidate takes a bound compare in S_BOUND and a pass
// through the bit-serial remainder unit, which takes one dividend bit per cycle.
// one word is in flight at a time; the input is ready again as soon as the
// verdict moves into the output register, even if that result has not yet
// been taken.
module primality_trial_division
    import ptd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [VALUE_BITS-1:0] i_number,
    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_is_prime
);

    // candidate stays below sqrt(2^VALUE_BITS) + 6, its square below 2^(VALUE_BITS+1)
    localparam int CAND_BITS = VALUE_BITS / 2 + 2;
    localparam int SQ_BITS   = VALUE_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_BOUND,
        S_DIV,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [VALUE_BITS-1:0] r_n;
    logic [CAND_BITS-1:0]  r_cand;
    logic [SQ_BITS-1:0]    r_sq;
    logic                  r_step_long;
    logic                  r_first;
    logic                  r_start;
    logic                  r_verdict;
    logic                  r_out_valid;
    logic                  r_is_prime;

    logic [CAND_BITS-1:0]  n_cand;
    logic [SQ_BITS-1:0]    n_sq;
    logic [SQ_BITS-1:0]    cand_ext;
    logic                  n_step_long;
    logic                  out_free;
    logic                  sq_over;
    t_rem_status           rem_status;

    // next candidate and its square: (c+s)^2 = c^2 + 2sc + s^2
    always_comb begin
        cand_ext = {{(SQ_BITS-CAND_BITS){1'b0}}, r_cand};
        if (r_step_long) begin
            n_cand = r_cand + CAND_BITS'(STEP_LONG);
            n_sq   = r_sq + (cand_ext << 3) + SQ_BITS'(STEP_LONG * STEP_LONG);
        end else begin
            n_cand = r_cand + CAND_BITS'(STEP_SHORT);
            n_sq   = r_sq + (cand_ext << 2) + SQ_BITS'(STEP_SHORT * STEP_SHORT);
        end
        // 3 -> 5 -> 7 both short, then alternate
        n_step_long = r_first ? 1'b0 : ~r_step_long;
    end

    assign sq_over  = r_sq > {1'b0, r_n};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // kick the remainder unit when the bound still allows a division
            r_start <= (r_state == S_BOUND) && !sq_over;
            // verdict moves in, or the waiting word is taken
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    // cheap cases: 0, 1, 2 and even values
                    r_cand      <= CAND_BITS'(FIRST_CAND);
                    r_sq        <= SQ_BITS'(FIRST_SQ);
                    r_step_long <= 1'b0;
                    r_first     <= 1'b1;
                    if (r_n == VALUE_BITS'(2)) begin
                        r_verdict <= 1'b1;
                        r_state   <= S_DONE;
                    end else if (r_n[VALUE_BITS-1:1] == '0 || !r_n[0]) begin
                        r_verdict <= 1'b0;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    if (sq_over) begin
                        r_verdict <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (rem_status.done) begin
                        if (rem_status.zero) begin
                            r_verdict <= 1'b0;
                            r_state   <= S_DONE;
                        end else begin
                            r_cand      <= n_cand;
                            r_sq        <= n_sq;
                            r_step_long <= n_step_long;
                            r_first     <= 1'b0;
                            r_state     <= S_BOUND;
                        end
                    end
                end
                S_DONE: begin
                    // wait for the output register to free up
                    if (out_free) begin
                        r_is_prime <= r_verdict;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // capture the value on accept
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_n <= i_number;
        end
    end

    ptd_rem #(
        .VALUE_BITS (VALUE_BITS)
    ) u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_start),
        .i_dividend (r_n),
        .i_divisor  (r_cand),
        .o_status   (rem_status)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_is_prime;

endmodule
`default_nettype wire

// ----- rtl/ptd_chk.sv -----
// port-level checker for the primality tester, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ptd_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire logic o_is_prime
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // one word in flight: input closes after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accept");

    // a new result only appears after the input was closed
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without work");

    // stalled result holds its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_is_prime)))
        else $error("stalled result dropped or changed");

endmodule

bind primality_trial_division ptd_chk u_ptd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_is_prime  (o_is_prime)
);
`default_nettype wire
